/* rtl/core/lrmc_pkg.sv */
`default_nettype none

package lrmc_pkg;

  // Field widths
  localparam int unsigned BTN_W      = 11;
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned DB_W       = 15;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned SQ_W       = 2 * AXIS_W - 1;   // x*x fits unsigned in 31 bits
  localparam int unsigned LIM_W      = 2 * DB_W;         // deadband squared
  localparam int unsigned MAG_W      = SQ_W + 1;         // x*x + y*y
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Button bit positions
  localparam int unsigned BTN_R1    = 0;
  localparam int unsigned BTN_L1    = 1;
  localparam int unsigned BTN_BOX   = 2;
  localparam int unsigned BTN_TRI   = 3;
  localparam int unsigned BTN_RING  = 4;
  localparam int unsigned BTN_RIGHT = 5;
  localparam int unsigned BTN_LEFT  = 6;
  localparam int unsigned BTN_UP    = 7;
  localparam int unsigned BTN_DOWN  = 8;
  localparam int unsigned BTN_L2    = 9;
  localparam int unsigned BTN_R2    = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISARM   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [DB_W-1:0]   DEADBAND_RST = 15'd3277;
  localparam logic [DIST_W-1:0] DISARM_RST   = 16'd50;

  // Mode codes as seen on the result channel
  localparam logic [MODE_W-1:0] MODE_CODE_UNARMED = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_STAND   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_WALK    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_WALK4   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_STAND4  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CODE_ROTATE  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CODE_DANCE   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CODE_LOOK    = 3'd7;

  // Internal one-hot mode state
  typedef enum logic [7:0] {
    MODE_UNARMED = 8'b0000_0001,
    MODE_STAND   = 8'b0000_0010,
    MODE_WALK    = 8'b0000_0100,
    MODE_WALK4   = 8'b0000_1000,
    MODE_STAND4  = 8'b0001_0000,
    MODE_ROTATE  = 8'b0010_0000,
    MODE_DANCE   = 8'b0100_0000,
    MODE_LOOK    = 8'b1000_0000
  } mode_e;

  // Payload of the squaring stage
  typedef struct packed {
    logic [BTN_W-1:0]  buttons;
    logic [DIST_W-1:0] distance_mm;
    logic [SQ_W-1:0]   x_sq;
    logic [SQ_W-1:0]   y_sq;
    logic [LIM_W-1:0]  lim_sq;
  } lrmc_sq_t;

  function automatic logic [MODE_W-1:0] mode_code(mode_e m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MODE_UNARMED: c = MODE_CODE_UNARMED;
      MODE_STAND:   c = MODE_CODE_STAND;
      MODE_WALK:    c = MODE_CODE_WALK;
      MODE_WALK4:   c = MODE_CODE_WALK4;
      MODE_STAND4:  c = MODE_CODE_STAND4;
      MODE_ROTATE:  c = MODE_CODE_ROTATE;
      MODE_DANCE:   c = MODE_CODE_DANCE;
      MODE_LOOK:    c = MODE_CODE_LOOK;
      default:      c = MODE_CODE_UNARMED;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lrmc_if.sv */
`default_nettype none

// Input channel: one control tick
interface lrmc_in_if;
  import lrmc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [BTN_W-1:0]         buttons;
  logic signed [AXIS_W-1:0] stick_x;
  logic signed [AXIS_W-1:0] stick_y;
  logic [DIST_W-1:0]        distance_mm;

  modport source (output valid, buttons, stick_x, stick_y, distance_mm, input ready);
  modport sink   (input valid, buttons, stick_x, stick_y, distance_mm, output ready);
  modport monitor (input valid, ready, buttons, stick_x, stick_y, distance_mm);
endinterface

// Result channel: mode, indices, enable level and pulses
interface lrmc_out_if;
  import lrmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  gait;
  logic [IDX_W-1:0]  stabiliser;
  logic              outputs_enabled;
  logic              center_servos;
  logic              reset_four_leg;
  logic              zero_body_angles;

  modport source (output valid, mode, gait, stabiliser, outputs_enabled, center_servos,
                  reset_four_leg, zero_body_angles, input ready);
  modport sink   (input valid, mode, gait, stabiliser, outputs_enabled, center_servos,
                  reset_four_leg, zero_body_angles, output ready);
  modport monitor (input valid, ready, mode, gait, stabiliser, outputs_enabled,
                   center_servos, reset_four_leg, zero_body_angles);
endinterface

`default_nettype wire

/* rtl/core/lrmc_sq_stage.sv */
`default_nettype none

// Input register with the stick and deadband squares
module lrmc_sq_stage (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  lrmc_in_if.sink                        in_i,
  input  wire logic [lrmc_pkg::DB_W-1:0] deadband_i,
  input  wire logic                      next_ready_i,
  output logic                           valid_o,
  output lrmc_pkg::lrmc_sq_t             data_o
);
  import lrmc_pkg::*;

  logic               valid_q, valid_d;
  lrmc_sq_t           data_q, data_d;
  logic signed [2*AXIS_W-1:0] x_prod, y_prod;
  logic [2*DB_W-1:0]  db_prod;
  logic               take;

  assign in_i.ready = !valid_q || next_ready_i;
  assign take       = in_i.valid && in_i.ready;

  // Squares; a full-scale negative axis squares to 2^30, still positive
  always_comb begin
    x_prod  = in_i.stick_x * in_i.stick_x;
    y_prod  = in_i.stick_y * in_i.stick_y;
    db_prod = deadband_i * deadband_i;
    data_d.buttons     = in_i.buttons;
    data_d.distance_mm = in_i.distance_mm;
    data_d.x_sq        = x_prod[SQ_W-1:0];
    data_d.y_sq        = y_prod[SQ_W-1:0];
    data_d.lim_sq      = db_prod[LIM_W-1:0];
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (next_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* rtl/core/lrmc_mode_fsm.sv */
`default_nettype none

// Mode state machine, index state and result register
module lrmc_mode_fsm #(
  parameter int unsigned GAIT_MODES = 4,
  parameter int unsigned STAB_MODES = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire lrmc_pkg::lrmc_sq_t          data_i,
  input  wire logic [lrmc_pkg::DIST_W-1:0] disarm_i,
  output logic                             ready_o,
  lrmc_out_if.source                       out_o
);
  import lrmc_pkg::*;

  localparam logic [IDX_W-1:0] GAIT_LAST = IDX_W'(GAIT_MODES - 1);
  localparam logic [IDX_W-1:0] STAB_LAST = IDX_W'(STAB_MODES - 1);

  mode_e             mode_q, mode_d;
  logic [IDX_W-1:0]  gait_q, gait_d;
  logic [IDX_W-1:0]  stab_q, stab_d;
  logic [IDX_W-1:0]  saved_q, saved_d;
  logic              en_q, en_d;
  logic [BTN_W-1:0]  prev_q;
  logic              out_valid_q;
  logic              center_q, center_d;
  logic              reset4_q, reset4_d;
  logic              zero_q, zero_d;

  logic [BTN_W-1:0]  press, rel;
  logic [MAG_W-1:0]  mag;
  logic              outside, disarm, adv;

  function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] v, logic [IDX_W-1:0] last);
    return (v == last) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_dn(logic [IDX_W-1:0] v, logic [IDX_W-1:0] last);
    return (v == '0) ? last : v - 1'b1;
  endfunction

  assign ready_o = !out_valid_q || out_o.ready;
  assign adv     = valid_i && ready_o;

  // Edges and stick magnitude
  assign press   = data_i.buttons & ~prev_q;
  assign rel     = ~data_i.buttons & prev_q;
  assign mag     = {1'b0, data_i.x_sq} + {1'b0, data_i.y_sq};
  assign outside = mag > {{(MAG_W - LIM_W){1'b0}}, data_i.lim_sq};
  assign disarm  = press[BTN_R1] || (data_i.distance_mm <= disarm_i);

  // Next-state rules, disarm first
  always_comb begin
    mode_d   = mode_q;
    gait_d   = gait_q;
    stab_d   = stab_q;
    saved_d  = saved_q;
    en_d     = en_q;
    center_d = 1'b0;
    reset4_d = 1'b0;
    zero_d   = 1'b0;
    if (disarm) begin
      mode_d = MODE_UNARMED;
      en_d   = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_UNARMED: begin
          if (press[BTN_L1]) begin
            mode_d   = MODE_STAND;
            en_d     = 1'b1;
            center_d = 1'b1;
          end
        end
        MODE_STAND, MODE_WALK: begin
          priority if (press[BTN_BOX]) begin
            mode_d   = MODE_STAND4;
            reset4_d = 1'b1;
          end else if (press[BTN_TRI]) begin
            mode_d = MODE_DANCE;
          end else if (press[BTN_RIGHT]) begin
            gait_d = step_up(gait_q, GAIT_LAST);
          end else if (press[BTN_LEFT]) begin
            gait_d = step_dn(gait_q, GAIT_LAST);
          end else if (press[BTN_UP]) begin
            stab_d = step_up(stab_q, STAB_LAST);
          end else if (press[BTN_DOWN]) begin
            stab_d = step_dn(stab_q, STAB_LAST);
          end else if (data_i.buttons[BTN_L2]) begin
            mode_d = MODE_ROTATE;
          end else if (mode_q == MODE_STAND) begin
            if (data_i.buttons[BTN_R2]) begin
              saved_d = stab_q;
              mode_d  = MODE_LOOK;
            end else if (outside) begin
              mode_d = MODE_WALK;
            end
          end else if (!outside) begin
            mode_d = MODE_STAND;
          end
        end
        MODE_WALK4: begin
          if (press[BTN_RING]) begin
            mode_d = MODE_STAND;
          end else if (!outside) begin
            mode_d = MODE_STAND4;
          end
        end
        MODE_STAND4: begin
          if (press[BTN_RING]) begin
            mode_d = MODE_STAND;
          end else if (outside) begin
            mode_d = MODE_WALK4;
          end
        end
        MODE_ROTATE: begin
          if (rel[BTN_L2]) begin
            mode_d = MODE_STAND;
          end
        end
        MODE_DANCE: begin
          if (press[BTN_RING]) begin
            mode_d = MODE_STAND;
          end
        end
        MODE_LOOK: begin
          if (rel[BTN_R2]) begin
            mode_d = MODE_STAND;
            stab_d = saved_q;
            zero_d = 1'b1;
          end
        end
        default: begin
          mode_d = MODE_UNARMED;
          en_d   = 1'b0;
        end
      endcase
    end
  end

  // State doubles as the result payload; it moves only when a result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_UNARMED;
      gait_q      <= '0;
      stab_q      <= '0;
      saved_q     <= '0;
      en_q        <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        mode_q  <= mode_d;
        gait_q  <= gait_d;
        stab_q  <= stab_d;
        saved_q <= saved_d;
        en_q    <= en_d;
        prev_q  <= data_i.buttons;
      end
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
    end
  end

  // Pulse fields of the result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      center_q <= center_d;
      reset4_q <= reset4_d;
      zero_q   <= zero_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.mode             = mode_code(mode_q);
  assign out_o.gait             = gait_q;
  assign out_o.stabiliser       = stab_q;
  assign out_o.outputs_enabled  = en_q;
  assign out_o.center_servos    = center_q;
  assign out_o.reset_four_leg   = reset4_q;
  assign out_o.zero_body_angles = zero_q;

endmodule

`default_nettype wire

/* rtl/core/legged_robot_mode_controller.sv */
`default_nettype none

// Gamepad-driven mode controller for a legged robot. Each transaction on in_i is one control
// tick (button levels, left stick, range reading) and yields exactly one transaction on
// out_o with the mode, gait and stabiliser indices, the servo enable level and the
// center/reset/zero pulses. One tick is taken every clock cycle while out_o.ready is high.
// A tick is held first in the squaring register (stick and deadband squares), then in the
// mode update, whose state registers also hold the result. in_i.ready drops only while both
// stages are full and out_o.ready is low. The deadband (index 0, reset 3277) and the disarm
// range (index 1, reset 50) are written through cfg_we_i/cfg_idx_i/cfg_data_i, bits above the
// register width dropped. The user must write only while no tick is in flight; not enforced.
module legged_robot_mode_controller #(
  parameter int unsigned GAIT_MODES = 4,
  parameter int unsigned STAB_MODES = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lrmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lrmc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lrmc_in_if.sink                              in_i,
  lrmc_out_if.source                           out_o
);
  import lrmc_pkg::*;

  logic [DB_W-1:0]   deadband_q;
  logic [DIST_W-1:0] disarm_q;
  logic              sq_valid;
  lrmc_sq_t          sq_data;
  logic              fsm_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DEADBAND_RST;
      disarm_q   <= DISARM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEADBAND: deadband_q <= cfg_data_i[DB_W-1:0];
        CFG_DISARM:   disarm_q   <= cfg_data_i[DIST_W-1:0];
        default:      ;
      endcase
    end
  end

  lrmc_sq_stage u_sq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .deadband_i   (deadband_q),
    .next_ready_i (fsm_ready),
    .valid_o      (sq_valid),
    .data_o       (sq_data)
  );

  lrmc_mode_fsm #(
    .GAIT_MODES (GAIT_MODES),
    .STAB_MODES (STAB_MODES)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sq_valid),
    .data_i   (sq_data),
    .disarm_i (disarm_q),
    .ready_o  (fsm_ready),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

/* rtl/core/lrmc_checker.sv */
`default_nettype none

// Port-level checks for the mode controller
module lrmc_checker #(
  parameter int unsigned GAIT_MODES = 4,
  parameter int unsigned STAB_MODES = 4
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  lrmc_in_if.sink    in_i,
  lrmc_out_if.source out_o
);
  import lrmc_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.mode)
      && $stable(out_o.gait) && $stable(out_o.stabiliser)
      && $stable(out_o.outputs_enabled) && $stable(out_o.center_servos))
    else $error("result changed while stalled");

  // Servo power follows the armed state
  a_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.outputs_enabled == (out_o.mode != MODE_CODE_UNARMED)))
    else $error("enable level disagrees with mode");

  // Each pulse comes with the mode it leads into
  a_pulses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!out_o.center_servos || out_o.mode == MODE_CODE_STAND)
      && (!out_o.reset_four_leg || out_o.mode == MODE_CODE_STAND4)
      && (!out_o.zero_body_angles || out_o.mode == MODE_CODE_STAND))
    else $error("pulse with wrong mode");

  // Indices stay below their counts
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (32'(out_o.gait) < GAIT_MODES) && (32'(out_o.stabiliser) < STAB_MODES))
    else $error("index out of range");

  // With the result side free, a tick is never refused
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty result");

endmodule

bind legged_robot_mode_controller lrmc_checker #(
  .GAIT_MODES (GAIT_MODES),
  .STAB_MODES (STAB_MODES)
) u_lrmc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

`default_nettype wire
